// ----- src/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority task queue
// Item formats, the stored task record, command and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] task_id;
        logic [7:0]  priority_req;
        logic [15:0] burst_time;
        logic [15:0] remaining_time;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_id;
        logic [7:0]  out_priority;
        logic [15:0] out_burst;
        logic [15:0] out_remaining;
        logic [4:0]  count;
    } rsp_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] remain;
    } entry_t;

endpackage
`default_nettype wire

// ----- src/sorted_priority_task_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Enqueue moves back each stored entry of lower priority than the new task
//   (0..CAPACITY-1 of them); dequeue moves every remaining entry forward one
//   place; a rejected item leaves the record store untouched.
// Throughput: one item at a time; the single priority comparator and the single
//   memory port pair walk the record store one entry per cycle.
// Reset: asynchronous, active low; empties the queue at once, no clearing pass.
// ----------------------------------------------------------------------------
// sorted_priority_task_queue: ready queue of task records, highest priority first
// Enqueue inserts behind all entries of equal or higher priority; dequeue pops
// the front record and moves the rest forward one place.
// ----------------------------------------------------------------------------
module sorted_priority_task_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_ENQ_SCAN = 6'b000010,
        S_ENQ_PUT  = 6'b000100,
        S_DEQ_HEAD = 6'b001000,
        S_DEQ_MOVE = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t    state_reg,     state_next;
    req_item_t item_reg,      item_next;
    logic [AW-1:0] pos_reg,   pos_next;
    logic [CW-1:0] fill_reg,  fill_next;
    rsp_item_t pend_reg,      pend_next;
    rsp_item_t rsp_reg,       rsp_next;
    logic      rsp_valid_reg, rsp_valid_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    entry_t new_entry;
    logic   move_back;

    spq_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign new_entry = '{id:     item_reg.task_id,
                         prio:   item_reg.priority_req,
                         burst:  item_reg.burst_time,
                         remain: item_reg.remaining_time};

    // The one shared comparator: does the stored record yield to the new task?
    assign move_back = (ram_rdata.prio < item_reg.priority_req);

    // Take a new item only while the sequencer is idle; the result register
    // on the output side is drained independently.
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        pend_next  = pend_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = ram_rdata;
        ram_raddr  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    pend_next = '0;
                    if (req.cmd == CMD_ENQ)
                    begin
                        if (fill_reg == CW'(CAPACITY))
                        begin
                            // Full: reject, leave queue untouched
                            pend_next.status = ST_FULL;
                            pend_next.count  = 5'(fill_reg);
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            // Start the scan at the tail
                            pos_next = AW'(fill_reg);
                            if (fill_reg == '0)
                            begin
                                state_next = S_ENQ_PUT;
                            end
                            else
                            begin
                                ram_raddr  = AW'(fill_reg - CW'(1));
                                state_next = S_ENQ_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        if (fill_reg == '0)
                        begin
                            pend_next.status = ST_EMPTY;
                            pend_next.count  = 5'(fill_reg);
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            state_next = S_DEQ_HEAD;
                        end
                    end
                end
            end

            S_ENQ_SCAN:
            begin
                // ram_rdata holds the record just ahead of pos_reg
                ram_we = 1'b1;
                if (move_back)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_ENQ_PUT;
                    end
                    else
                    begin
                        ram_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    ram_wdata        = new_entry;
                    fill_next        = fill_reg + CW'(1);
                    pend_next.status = ST_OK;
                    pend_next.count  = 5'(fill_reg + CW'(1));
                    state_next       = S_DONE;
                end
            end

            S_ENQ_PUT:
            begin
                ram_we           = 1'b1;
                ram_wdata        = new_entry;
                fill_next        = fill_reg + CW'(1);
                pend_next.status = ST_OK;
                pend_next.count  = 5'(fill_reg + CW'(1));
                state_next       = S_DONE;
            end

            S_DEQ_HEAD:
            begin
                // Front record arrives; capture it and start the forward move
                pend_next.status        = ST_OK;
                pend_next.out_id        = ram_rdata.id;
                pend_next.out_priority  = ram_rdata.prio;
                pend_next.out_burst     = ram_rdata.burst;
                pend_next.out_remaining = ram_rdata.remain;
                pend_next.count         = 5'(fill_reg - CW'(1));
                fill_next               = fill_reg - CW'(1);
                pos_next                = '0;
                if (fill_reg == CW'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = AW'(1);
                    state_next = S_DEQ_MOVE;
                end
            end

            S_DEQ_MOVE:
            begin
                // fill_reg already holds the new count here
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if ((CW'(pos_reg) + CW'(1)) == fill_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr = pos_reg + AW'(2);
                    pos_next  = pos_reg + AW'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: load from the pending result once the slot is free
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall))
        begin
            rsp_next       = pend_reg;
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        pos_reg  <= pos_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_idle_holds_fill : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (state_reg != S_DONE) || $stable(fill_reg))
        else $error("queue changed on a rejected item");

    a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_FULL)) |-> (rsp.count == 5'(CAPACITY)))
        else $error("full rejection with count below capacity");

    a_reject_no_task : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |->
            ((rsp.out_id == '0) && (rsp.out_priority == '0) &&
             (rsp.out_burst == '0) && (rsp.out_remaining == '0)))
        else $error("rejected item carries task data");

endmodule
`default_nettype wire

// ----- src/spq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram: task record store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram
    import spq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire entry_t        wdata,
    input  wire logic [AW-1:0] raddr,
    output entry_t             rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
